>>> src/pdh_pkg.sv
package pdh_pkg;

  // fixed widths of the transaction fields
  localparam int CHANNEL_W   = 2;
  localparam int INTENS_W    = 8;
  localparam int COUNT_OUT_W = 16;
  localparam int COORD_W     = 8;

  // colour band codes
  localparam logic [CHANNEL_W-1:0] BAND_RED   = 2'd0;
  localparam logic [CHANNEL_W-1:0] BAND_GREEN = 2'd1;
  localparam logic [CHANNEL_W-1:0] BAND_BLUE  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_BAND,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

>>> src/point_density_heatmap.sv
// point density heatmap: 2-d hit counter with a three-band heat colour
//
// input channel (in_valid / in_stall) carries one point pos_x, pos_y per
// transaction; coordinates at or above GRID_SIDE are clamped to the last cell.
// output channel (out_valid / out_stall) returns one transaction per point:
// the new saturated count of the hit cell, the running peak count, the colour
// band (red, green, blue) and its intensity floor(255 * (3 * count / peak - band)).
//
// after reset the count memory is swept to zero one cell per cycle, over all
// GRID_SIDE * GRID_SIDE cells (65536 at the default size); in_stall stays high
// for the whole sweep.
// each point goes through one memory read, one write back with the peak update,
// one band compare, then the restoring divider producing 8 quotient bits at one
// per cycle; the finished result is then loaded into the output register, which
// drives out_valid.
// a stalled result sits in the output register while the next point is already
// being worked on; a new point is taken only in idle, once the last one's result
// has moved out, and a finished result is held back while that register is stalled.
module point_density_heatmap #(
  parameter int GRID_SIDE  = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pdh_pkg::COORD_W-1:0]        pos_x,
  input  logic [pdh_pkg::COORD_W-1:0]        pos_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pdh_pkg::CHANNEL_W-1:0]      channel,
  output logic [pdh_pkg::INTENS_W-1:0]       intensity,
  output logic [pdh_pkg::COUNT_OUT_W-1:0]    cell_count,
  output logic [pdh_pkg::COUNT_OUT_W-1:0]    peak
);
  import pdh_pkg::*;

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int IW    = $clog2(DEPTH);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  state_t state, state_next;

  // count memory, one read and one write port
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data;
  logic                  mem_we;
  logic [IW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  logic [CW-1:0]         x_c;
  logic [CW-1:0]         y_c;
  logic [IW-1:0]         rd_addr;
  logic [IW-1:0]         idx_r;
  logic [IW-1:0]         clr_idx;

  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [COUNT_BITS-1:0] peak_r;
  logic [COUNT_BITS-1:0] peak_next;
  logic [CHANNEL_W-1:0]  band_r;
  logic [COUNT_BITS-1:0] num_r;

  logic [COUNT_BITS+1:0] c3;
  logic [COUNT_BITS+1:0] p1;
  logic [COUNT_BITS+1:0] p2;

  logic                  in_take;
  logic                  out_free;
  logic                  load_out;
  logic                  div_start;
  logic                  div_done;
  logic [INTENS_W-1:0]   div_quot;

  // clamp coordinates onto the grid and form the cell address
  always_comb begin
    if (32'(pos_x) >= GRID_SIDE) x_c = CW'(GRID_SIDE - 1);
    else                         x_c = CW'(pos_x);
    if (32'(pos_y) >= GRID_SIDE) y_c = CW'(GRID_SIDE - 1);
    else                         y_c = CW'(pos_y);
    rd_addr = IW'(x_c) * IW'(GRID_SIDE) + IW'(y_c);
  end

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // saturating increment and peak tracking on the word just read
  always_comb begin
    cnt_next  = (rd_data == COUNT_MAX) ? rd_data : rd_data + COUNT_BITS'(1);
    peak_next = (cnt_next > peak_r) ? cnt_next : peak_r;
  end

  // exact band edges: red if 3c <= p, green if 3c <= 2p, else blue
  assign c3 = (COUNT_BITS+2)'(cnt_r) + ((COUNT_BITS+2)'(cnt_r) << 1);
  assign p1 = (COUNT_BITS+2)'(peak_r);
  assign p2 = (COUNT_BITS+2)'(peak_r) << 1;

  // memory write port: clearing sweep or write back of the updated count
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = idx_r;
    wr_data = cnt_next;
    if (state == ST_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_idx;
      wr_data = '0;
    end else if (state == ST_UPDATE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == IW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = ST_UPDATE;
      end
      ST_UPDATE: state_next = ST_BAND;
      ST_BAND:   state_next = ST_LOAD;
      ST_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // clear sweep counter and peak register
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      peak_r  <= '0;
    end else begin
      if (state == ST_CLEAR) clr_idx <= clr_idx + IW'(1);
      if (state == ST_UPDATE) peak_r <= peak_next;
    end
  end

  // per-point working registers
  always_ff @(posedge clk) begin
    if (in_take) idx_r <= rd_addr;
    if (state == ST_UPDATE) cnt_r <= cnt_next;
    if (state == ST_BAND) begin
      if (c3 <= p1) begin
        band_r <= BAND_RED;
        num_r  <= COUNT_BITS'(c3);
      end else if (c3 <= p2) begin
        band_r <= BAND_GREEN;
        num_r  <= COUNT_BITS'(c3 - p1);
      end else begin
        band_r <= BAND_BLUE;
        num_r  <= COUNT_BITS'(c3 - p2);
      end
    end
  end

  pdh_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (num_r),
    .denom (peak_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // output register parts the result from the next point's work
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      channel    <= band_r;
      intensity  <= div_quot;
      cell_count <= COUNT_OUT_W'(cnt_r);
      peak       <= COUNT_OUT_W'(peak_r);
    end
  end

  // no point taken during the clearing sweep
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_CLEAR && in_take))
    else $error("point accepted during clear sweep");

  // the count handed to the divider is nonzero and never above the peak
  a_cnt_le_peak: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (cnt_r != '0 && cnt_r <= peak_r))
    else $error("cell count above peak or zero");

  // the peak never falls
  a_peak_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> peak_r >= $past(peak_r))
    else $error("peak decreased");

  // divider finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider done outside divide state");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("output register overwritten");

endmodule

>>> src/pdh_div.sv
module pdh_div #(
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [COUNT_BITS-1:0]           numer,
  input  logic [COUNT_BITS-1:0]           denom,
  output logic                            done,
  output logic [pdh_pkg::INTENS_W-1:0]    quot
);
  import pdh_pkg::*;

  localparam int DW = COUNT_BITS + INTENS_W;
  localparam int SW = $clog2(INTENS_W);

  logic [DW-1:0]         dvd;
  logic [COUNT_BITS-1:0] rem;
  logic [INTENS_W-1:0]   low;
  logic [COUNT_BITS-1:0] dsr;
  logic [SW-1:0]         step;
  logic                  busy;
  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS:0]   trial;

  // dividend is numer * 255, always below 256 * denom
  assign dvd     = (DW'(numer) << INTENS_W) - DW'(numer);
  assign shifted = {rem, low[INTENS_W-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == SW'(INTENS_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dvd[DW-1:INTENS_W];
      low  <= dvd[INTENS_W-1:0];
      dsr  <= denom;
      step <= '0;
      quot <= '0;
    end else if (busy) begin
      step <= step + SW'(1);
      low  <= low << 1;
      if (!trial[COUNT_BITS]) begin
        rem  <= trial[COUNT_BITS-1:0];
        quot <= {quot[INTENS_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[COUNT_BITS-1:0];
        quot <= {quot[INTENS_W-2:0], 1'b0};
      end
    end
  end

endmodule
